[rtl/srvb_pkg.sv]
// ----------------------------------------------------------------------------
// srvb_pkg
// Shared types, operation codes and constants of the comb/allpass reverb.
// ----------------------------------------------------------------------------
package srvb_pkg;

	// Default configuration of the block.
	localparam int COMB_COUNT_DEF      = 4;
	localparam int COMB_DEPTH_DEF      = 4096;
	localparam int AP_DELAY_FIRST_DEF  = 240;
	localparam int AP_DELAY_SECOND_DEF = 81;
	localparam int SAMPLE_BITS_DEF     = 16;

	// Register file layout.
	localparam int GAIN_BITS     = 16;
	localparam int LEN_BITS      = 12;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_REGS      = 4;
	localparam int COMB_SEL_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEN_0  = 3'd4;

	// Reset delay lengths of the four combs.
	localparam logic [LEN_BITS-1:0] LEN_RST_0 = 12'd1426;
	localparam logic [LEN_BITS-1:0] LEN_RST_1 = 12'd1781;
	localparam logic [LEN_BITS-1:0] LEN_RST_2 = 12'd1973;
	localparam logic [LEN_BITS-1:0] LEN_RST_3 = 12'd2098;

	// Fixed Q0.16 gains: 0.7 for the allpasses and the wet path, 0.3 dry.
	localparam int COEF_BITS = 17;
	localparam logic signed [COEF_BITS-1:0] AP_GAIN  = 17'sd45875;
	localparam logic signed [COEF_BITS-1:0] WET_GAIN = 17'sd45875;
	localparam logic signed [COEF_BITS-1:0] DRY_GAIN = 17'sd19661;

	// Datapath operations issued by the controller.
	localparam int OP_BITS = 4;
	localparam logic [OP_BITS-1:0] OP_NOP   = 4'd0;
	localparam logic [OP_BITS-1:0] OP_CLR   = 4'd1;
	localparam logic [OP_BITS-1:0] OP_LOAD  = 4'd2;
	localparam logic [OP_BITS-1:0] OP_SHARE = 4'd3;
	localparam logic [OP_BITS-1:0] OP_CRD   = 4'd4;
	localparam logic [OP_BITS-1:0] OP_CMUL  = 4'd5;
	localparam logic [OP_BITS-1:0] OP_CWR   = 4'd6;
	localparam logic [OP_BITS-1:0] OP_ARD   = 4'd7;
	localparam logic [OP_BITS-1:0] OP_AMUL1 = 4'd8;
	localparam logic [OP_BITS-1:0] OP_AW    = 4'd9;
	localparam logic [OP_BITS-1:0] OP_AMUL2 = 4'd10;
	localparam logic [OP_BITS-1:0] OP_AY    = 4'd11;
	localparam logic [OP_BITS-1:0] OP_MX1   = 4'd12;
	localparam logic [OP_BITS-1:0] OP_MX2   = 4'd13;
	localparam logic [OP_BITS-1:0] OP_MX3   = 4'd14;

	// Command from controller to datapath.
	typedef struct packed {
		logic [OP_BITS-1:0]       op;
		logic [COMB_SEL_BITS-1:0] comb;
		logic                     ap;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic clr_done;
		logic out_free;
	} status_t;

endpackage

[rtl/srvb_ctrl.sv]
// ----------------------------------------------------------------------------
// srvb_ctrl
// Sequencer that steps one sample through the combs, allpasses and mix.
// ----------------------------------------------------------------------------
module srvb_ctrl #(
	parameter int COMB_COUNT = srvb_pkg::COMB_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  srvb_pkg::status_t status,
	output srvb_pkg::cmd_t    cmd
);
	import srvb_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SHARE = 4'd2;
	localparam logic [3:0] ST_CRD   = 4'd3;
	localparam logic [3:0] ST_CMUL  = 4'd4;
	localparam logic [3:0] ST_CWR   = 4'd5;
	localparam logic [3:0] ST_ARD   = 4'd6;
	localparam logic [3:0] ST_AMUL1 = 4'd7;
	localparam logic [3:0] ST_AW    = 4'd8;
	localparam logic [3:0] ST_AMUL2 = 4'd9;
	localparam logic [3:0] ST_AY    = 4'd10;
	localparam logic [3:0] ST_MX1   = 4'd11;
	localparam logic [3:0] ST_MX2   = 4'd12;
	localparam logic [3:0] ST_MX3   = 4'd13;

	localparam logic [COMB_SEL_BITS-1:0] LAST_COMB = COMB_SEL_BITS'(COMB_COUNT - 1);

	logic [3:0]               state_q, state_nx;
	logic [COMB_SEL_BITS-1:0] k_q;
	logic                     ap_q;

	// Next state and command decode.
	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NOP;
		cmd.comb = k_q;
		cmd.ap   = ap_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLR;
				if (status.clr_done) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = ST_SHARE;
				end
			end
			ST_SHARE: begin
				cmd.op   = OP_SHARE;
				state_nx = ST_CRD;
			end
			ST_CRD: begin
				cmd.op   = OP_CRD;
				state_nx = ST_CMUL;
			end
			ST_CMUL: begin
				cmd.op   = OP_CMUL;
				state_nx = ST_CWR;
			end
			ST_CWR: begin
				cmd.op   = OP_CWR;
				state_nx = (k_q == LAST_COMB) ? ST_ARD : ST_CRD;
			end
			ST_ARD: begin
				cmd.op   = OP_ARD;
				state_nx = ST_AMUL1;
			end
			ST_AMUL1: begin
				cmd.op   = OP_AMUL1;
				state_nx = ST_AW;
			end
			ST_AW: begin
				cmd.op   = OP_AW;
				state_nx = ST_AMUL2;
			end
			ST_AMUL2: begin
				cmd.op   = OP_AMUL2;
				state_nx = ST_AY;
			end
			ST_AY: begin
				cmd.op   = OP_AY;
				state_nx = ap_q ? ST_MX1 : ST_ARD;
			end
			ST_MX1: begin
				cmd.op   = OP_MX1;
				state_nx = ST_MX2;
			end
			ST_MX2: begin
				cmd.op   = OP_MX2;
				state_nx = ST_MX3;
			end
			ST_MX3: begin
				// The result waits here until the output register is free.
				if (status.out_free) begin
					cmd.op   = OP_MX3;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// State, comb counter and allpass select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			k_q     <= '0;
			ap_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CWR) begin
				k_q <= (k_q == LAST_COMB) ? '0 : k_q + 1'b1;
			end
			if (state_q == ST_AY) begin
				ap_q <= ~ap_q;
			end
		end
	end

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SHARE)
		else $error("accepted beat did not start the sequence");
	a_last_comb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CWR && k_q == LAST_COMB |=> state_q == ST_ARD && k_q == '0)
		else $error("comb sweep did not end in the allpass stages");
	a_second_ap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AY && ap_q |=> state_q == ST_MX1 && !ap_q)
		else $error("second allpass did not lead to the mix");
`endif

endmodule

[rtl/srvb_dp.sv]
// ----------------------------------------------------------------------------
// srvb_dp
// Datapath: configuration registers, delay memories, shared multiplier,
// accumulators and the output register.
// ----------------------------------------------------------------------------
module srvb_dp #(
	parameter int COMB_COUNT      = srvb_pkg::COMB_COUNT_DEF,
	parameter int COMB_DEPTH      = srvb_pkg::COMB_DEPTH_DEF,
	parameter int AP_DELAY_FIRST  = srvb_pkg::AP_DELAY_FIRST_DEF,
	parameter int AP_DELAY_SECOND = srvb_pkg::AP_DELAY_SECOND_DEF,
	parameter int SAMPLE_BITS     = srvb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [srvb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [srvb_pkg::GAIN_BITS-1:0]      cfg_wdata,
	input  logic [SAMPLE_BITS-1:0]              in_sample,
	input  srvb_pkg::cmd_t                      cmd,
	output srvb_pkg::status_t                   status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [SAMPLE_BITS-1:0]              out_sample
);
	import srvb_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int SW  = SB + 2;
	localparam int AW  = SB + 4;
	localparam int PW  = AW + COEF_BITS;
	localparam int RW  = PW - 14;
	localparam int TOT = COMB_COUNT * COMB_DEPTH;
	localparam int CAW = $clog2(TOT);
	localparam int CIW = $clog2(COMB_DEPTH);
	localparam int CKW = $clog2(COMB_COUNT);
	localparam int CW  = (($clog2(COMB_DEPTH + 1) > LEN_BITS) ?
		$clog2(COMB_DEPTH + 1) : LEN_BITS) + 1;
	localparam int A1W = (AP_DELAY_FIRST > 1) ? $clog2(AP_DELAY_FIRST) : 1;
	localparam int A2W = (AP_DELAY_SECOND > 1) ? $clog2(AP_DELAY_SECOND) : 1;
	localparam int APM = (AP_DELAY_FIRST > AP_DELAY_SECOND) ?
		AP_DELAY_FIRST : AP_DELAY_SECOND;
	localparam int CLR_LEN = (TOT > APM) ? TOT : APM;
	localparam int CLW = $clog2(CLR_LEN);

	// Floor division of the input by the comb count: reciprocal, then fix-up.
	localparam int SHS = SB + 2;
	localparam logic [SHS:0] SHM = (SHS + 1)'((64'd1 << SHS) / COMB_COUNT);
	localparam int SPW = SB + 1 + SHS + 1;
	localparam logic [SB:0] SHB = (SB + 1)'((3 * (64'd1 << (SB - 1))) / COMB_COUNT);

	localparam logic signed [RW-1:0] SW_MAX = RW'((64'd1 << (SW - 1)) - 1);
	localparam logic signed [RW-1:0] SW_MIN = -SW_MAX - RW'(1);
	localparam logic signed [RW-1:0] SB_MAX = RW'((64'd1 << (SB - 1)) - 1);
	localparam logic signed [RW-1:0] SB_MIN = -SB_MAX - RW'(1);

	// Round half up, Q16 to integer.
	function automatic logic signed [PW-16:0] rnd16(input logic signed [PW:0] p);
		logic [PW:0] t;
		t = p + (PW + 1)'(32768);
		return $signed(t[PW:16]);
	endfunction

	function automatic logic signed [SW-1:0] sat_sw(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] r;
		r = (v > SW_MAX) ? SW_MAX : ((v < SW_MIN) ? SW_MIN : v);
		return r[SW-1:0];
	endfunction

	function automatic logic signed [SB-1:0] sat_sb(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] r;
		r = (v > SB_MAX) ? SB_MAX : ((v < SB_MIN) ? SB_MIN : v);
		return r[SB-1:0];
	endfunction

	// Configuration registers.
	logic [GAIN_BITS-1:0] gain_q [CFG_REGS];
	logic [LEN_BITS-1:0]  len_q  [CFG_REGS];

	// Memories and their read registers.
	logic signed [SW-1:0] comb_mem [TOT];
	logic signed [SW-1:0] ap1_mem  [AP_DELAY_FIRST];
	logic signed [SW-1:0] ap2_mem  [AP_DELAY_SECOND];
	logic signed [SW-1:0] comb_rd_q, ap1_rd_q, ap2_rd_q;

	// Working registers.
	logic [CLW-1:0]          clr_q;
	logic [CIW-1:0]          cidx_q [COMB_COUNT];
	logic [A1W-1:0]          ap1_idx_q;
	logic [A2W-1:0]          ap2_idx_q;
	logic [CAW-1:0]          pos_q;
	logic signed [SB-1:0]    x_q, share_q;
	logic [SPW-1:0]          shp_q;
	logic signed [AW-1:0]    wet_q, d_q, y_q;
	logic signed [SW-1:0]    w_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [PW:0]      acc_q;
	logic signed [SB-1:0]    out_q;
	logic                    out_valid_q;

	// Combinational helpers.
	logic [CKW-1:0]          kk;
	logic [CW-1:0]           len_raw, len_e, w_e, w_nx;
	logic [CAW-1:0]          pos;
	logic [SB:0]             u_in, u_x, q0, q1, r0;
	logic signed [AW-1:0]    mul_a, ap_x, ap_rd;
	logic signed [COEF_BITS-1:0] mul_b;
	logic signed [PW:0]      prod_x;
	logic                    clr_op, comb_we, ap1_we, ap2_we;
	logic [CAW-1:0]          comb_wa;
	logic [A1W-1:0]          ap1_wa;
	logic [A2W-1:0]          ap2_wa;
	logic signed [SW-1:0]    comb_wd, ap_wd, w_new;

	assign kk     = cmd.comb[CKW-1:0];
	assign clr_op = (cmd.op == OP_CLR);
	assign prod_x = (PW + 1)'(prod_q);

	// Comb position: effective length, wrapped index and next index.
	always_comb begin
		len_raw = CW'(len_q[cmd.comb]);
		if (len_raw == '0) begin
			len_e = CW'(1);
		end else if (len_raw > CW'(COMB_DEPTH)) begin
			len_e = CW'(COMB_DEPTH);
		end else begin
			len_e = len_raw;
		end
		w_e = CW'(cidx_q[kk]);
		if (w_e >= len_e) w_e = '0;
		w_nx = (w_e + CW'(1) >= len_e) ? '0 : w_e + CW'(1);
		pos  = CAW'(kk) * CAW'(COMB_DEPTH) + CAW'(w_e);
	end

	// Input share: bias the sample so that floor division is unsigned.
	always_comb begin
		u_in = {in_sample[SB-1], in_sample} + {2'b11, {(SB - 1){1'b0}}};
		u_x  = {x_q[SB-1], x_q} + {2'b11, {(SB - 1){1'b0}}};
		q0   = shp_q[SHS+SB:SHS];
		r0   = u_x - (SB + 1)'(q0 * (SB + 1)'(COMB_COUNT));
		q1   = (r0 >= (SB + 1)'(COMB_COUNT)) ? q0 + 1'b1 : q0;
	end

	// Shared multiplier operand selection.
	always_comb begin
		ap_x  = cmd.ap ? y_q : wet_q;
		ap_rd = cmd.ap ? AW'(ap2_rd_q) : AW'(ap1_rd_q);
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_CMUL: begin
				mul_a = AW'(comb_rd_q);
				mul_b = $signed({1'b0, gain_q[cmd.comb]});
			end
			OP_AMUL1: begin
				mul_a = ap_rd;
				mul_b = AP_GAIN;
			end
			OP_AMUL2: begin
				mul_a = AW'(w_q);
				mul_b = AP_GAIN;
			end
			OP_MX1: begin
				mul_a = AW'(x_q);
				mul_b = DRY_GAIN;
			end
			OP_MX2: begin
				mul_a = y_q;
				mul_b = WET_GAIN;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Memory write ports: clearing pass or the sequencer.
	always_comb begin
		w_new   = sat_sw(RW'(ap_x) + RW'(rnd16(prod_x)));
		comb_wd = clr_op ? '0 : sat_sw(RW'(share_q) + RW'(rnd16(prod_x)));
		ap_wd   = clr_op ? '0 : w_new;
		comb_we = (clr_op && ({1'b0, clr_q} < (CLW + 1)'(TOT))) || (cmd.op == OP_CWR);
		comb_wa = clr_op ? clr_q[CAW-1:0] : pos_q;
		ap1_we  = (clr_op && ({1'b0, clr_q} < (CLW + 1)'(AP_DELAY_FIRST))) ||
			(cmd.op == OP_AW && !cmd.ap);
		ap1_wa  = clr_op ? clr_q[A1W-1:0] : ap1_idx_q;
		ap2_we  = (clr_op && ({1'b0, clr_q} < (CLW + 1)'(AP_DELAY_SECOND))) ||
			(cmd.op == OP_AW && cmd.ap);
		ap2_wa  = clr_op ? clr_q[A2W-1:0] : ap2_idx_q;
	end

	// Comb delay memory, one segment per comb.
	always_ff @(posedge clk) begin
		if (comb_we) comb_mem[comb_wa] <= comb_wd;
		comb_rd_q <= comb_mem[pos];
	end

	// Allpass delay memories.
	always_ff @(posedge clk) begin
		if (ap1_we) ap1_mem[ap1_wa] <= ap_wd;
		ap1_rd_q <= ap1_mem[ap1_idx_q];
	end

	always_ff @(posedge clk) begin
		if (ap2_we) ap2_mem[ap2_wa] <= ap_wd;
		ap2_rd_q <= ap2_mem[ap2_idx_q];
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) gain_q[i] <= '0;
			len_q[0] <= LEN_RST_0;
			len_q[1] <= LEN_RST_1;
			len_q[2] <= LEN_RST_2;
			len_q[3] <= LEN_RST_3;
		end else if (cfg_we) begin
			if (cfg_index < REG_LEN_0) begin
				gain_q[cfg_index[1:0]] <= cfg_wdata;
			end else begin
				len_q[cfg_index[1:0]] <= cfg_wdata[LEN_BITS-1:0];
			end
		end
	end

	// Control state: clearing counter, delay indexes, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			for (int i = 0; i < COMB_COUNT; i++) cidx_q[i] <= '0;
			ap1_idx_q   <= '0;
			ap2_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_op) clr_q <= clr_q + 1'b1;
			if (cmd.op == OP_CRD) cidx_q[kk] <= w_nx[CIW-1:0];
			if (cmd.op == OP_AY && !cmd.ap) begin
				ap1_idx_q <= (ap1_idx_q == A1W'(AP_DELAY_FIRST - 1)) ? '0 : ap1_idx_q + 1'b1;
			end
			if (cmd.op == OP_AY && cmd.ap) begin
				ap2_idx_q <= (ap2_idx_q == A2W'(AP_DELAY_SECOND - 1)) ? '0 : ap2_idx_q + 1'b1;
			end
			if (cmd.op == OP_MX3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Arithmetic registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q   <= $signed(in_sample);
				shp_q <= SPW'(u_in) * SPW'(SHM);
				wet_q <= '0;
			end
			OP_SHARE: begin
				share_q <= $signed(SB'(q1 - SHB));
			end
			OP_CRD: begin
				pos_q <= pos;
			end
			OP_CMUL: begin
				prod_q <= mul_a * mul_b;
				wet_q  <= wet_q + AW'(comb_rd_q);
			end
			OP_AMUL1: begin
				prod_q <= mul_a * mul_b;
				d_q    <= ap_rd;
			end
			OP_AW: begin
				w_q <= w_new;
			end
			OP_AMUL2: begin
				prod_q <= mul_a * mul_b;
			end
			OP_AY: begin
				y_q <= AW'(RW'(d_q) - RW'(rnd16(prod_x)));
			end
			OP_MX1: begin
				prod_q <= mul_a * mul_b;
			end
			OP_MX2: begin
				acc_q  <= prod_x;
				prod_q <= mul_a * mul_b;
			end
			OP_MX3: begin
				out_q <= sat_sb(RW'(rnd16(acc_q + prod_x)));
			end
			default: begin
			end
		endcase
	end

	assign status.clr_done = (clr_q == CLW'(CLR_LEN - 1));
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_sample      = out_q;

`ifndef SYNTH
	a_out_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.op) == OP_MX3)
		else $error("output became valid without a mix step");
	a_read_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CMUL |-> $past(cmd.op) == OP_CRD)
		else $error("comb read data used without a preceding read");
	a_cidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(cidx_q[0]) < CW'(COMB_DEPTH))
		else $error("comb index beyond the segment");
`endif

endmodule

[rtl/schroeder_comb_allpass_reverb.sv]
// ----------------------------------------------------------------------------
// schroeder_comb_allpass_reverb
// Mono reverberator: parallel feedback combs, two series allpasses and a
// fixed 0.3 dry / 0.7 wet mix, saturated to the sample width.
// ----------------------------------------------------------------------------
// Usage:
// Dry samples enter as beats on the s_ channel, one reverberated sample
// leaves on the m_ channel for each. The user must write comb gains and
// lengths on the cfg port only while the block is idle; the block itself
// does not enforce it. Index 0 to 3 are the gains, 4 to 7 the lengths.
// After reset a clearing pass zeroes all delay memories, one entry per
// cycle; s_tready stays low until it ends.
// Beats are accepted only in the idle state, so a new beat waits until the
// previous sample is through: after the accepting state come one state for
// the input share, three per comb, five per allpass and three for the mix,
// all through one shared multiplier. s_tready rises again in the same cycle
// as the result appears on m_tvalid. The result sits in an output register;
// when the receiver stalls, the next sample is accepted and computed, and
// only its final mix step waits for the register to empty.
// ----------------------------------------------------------------------------
module schroeder_comb_allpass_reverb #(
	parameter int COMB_COUNT      = srvb_pkg::COMB_COUNT_DEF,
	parameter int COMB_DEPTH      = srvb_pkg::COMB_DEPTH_DEF,
	parameter int AP_DELAY_FIRST  = srvb_pkg::AP_DELAY_FIRST_DEF,
	parameter int AP_DELAY_SECOND = srvb_pkg::AP_DELAY_SECOND_DEF,
	parameter int SAMPLE_BITS     = srvb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample_in
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,  // sample_out
	input  logic                                  cfg_we,
	input  logic [srvb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [srvb_pkg::GAIN_BITS-1:0]        cfg_wdata
);
	import srvb_pkg::*;

	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

	cmd_t                   cmd;
	status_t                status;
	logic [SAMPLE_BITS-1:0] out_sample;

	srvb_ctrl #(
		.COMB_COUNT(COMB_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	srvb_dp #(
		.COMB_COUNT     (COMB_COUNT),
		.COMB_DEPTH     (COMB_DEPTH),
		.AP_DELAY_FIRST (AP_DELAY_FIRST),
		.AP_DELAY_SECOND(AP_DELAY_SECOND),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_sample (s_tdata[SAMPLE_BITS-1:0]),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_sample(out_sample)
	);

	assign m_tdata = DW'(out_sample);

endmodule
